// File: sv/rslr_pkg.sv
package rslr_pkg;

    // Default depth of the column table, one entry per sample position.
    localparam int MAX_LINE_SAMPLES_DEF = 4096;

    // Width of a source sample that is kept; higher bits of the field are cleared.
    localparam int SAMPLE_BITS = 16;

    // Largest channel count that the counters honor.
    localparam int MAX_CHANNELS = 4;

    // Field widths of the channels.
    localparam int INDEX_W  = 12;
    localparam int COLUMN_W = 13;
    localparam int PIXEL_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } rslr_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_SAMPLES   = 3'd0,
        CFG_LINE_COUNT     = 3'd1,
        CFG_CHANNEL_COUNT  = 3'd2,
        CFG_CHANNEL_SELECT = 3'd3,
        CFG_OUT_LINE_WIDTH = 3'd4
    } rslr_cfg_idx_t;

    // Input item.
    typedef struct packed {
        rslr_cmd_t             cmd;
        logic [INDEX_W-1:0]    table_index;
        logic [COLUMN_W-1:0]   table_column;
        logic [PIXEL_W-1:0]    sample_value;
    } rslr_in_t;

    // Result item: one pixel write into the destination image.
    typedef struct packed {
        logic [12:0]         dest_row;
        logic [COLUMN_W-1:0] dest_column;
        logic [PIXEL_W-1:0]  pixel_value;
        logic                frame_end;
    } rslr_out_t;

    // Configuration as the datapath uses it, line and channel counts already clamped.
    typedef struct packed {
        logic [12:0] line_samples;
        logic [12:0] line_count;
        logic [2:0]  channel_count;
        logic [1:0]  channel_select;
        logic [12:0] out_line_width;
    } rslr_cfg_t;

    // Access to the column table for the current transfer.
    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        logic [COLUMN_W-1:0] wr_data;
    } rslr_mem_cmd_t;

    // Everything about a pending write except the table entry itself.
    typedef struct packed {
        logic                forward;
        logic [12:0]         row;
        logic [PIXEL_W-1:0]  pixel;
        logic                frame_end;
    } rslr_tag_t;

endpackage

// File: sv/rslr_cfg_regs.sv
module rslr_cfg_regs #(
    parameter int MAX_LINE_SAMPLES = rslr_pkg::MAX_LINE_SAMPLES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rslr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rslr_pkg::CFG_DATA_W-1:0] cfg_data,
    output rslr_pkg::rslr_cfg_t            cfg
);
    import rslr_pkg::*;

    localparam logic [12:0] LS_RESET = (1024 > MAX_LINE_SAMPLES) ?
                                       13'(MAX_LINE_SAMPLES) : 13'd1024;
    localparam logic [12:0] LC_RESET = (512 > MAX_LINE_SAMPLES) ?
                                       13'(MAX_LINE_SAMPLES) : 13'd512;

    rslr_cfg_t cfg_reg, cfg_next;
    logic      wr_en;

    // A size of zero counts as one; a size above the table depth counts as the depth.
    function automatic logic [12:0] clamp_lines(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (int'(v) > MAX_LINE_SAMPLES) begin
            r = 13'(MAX_LINE_SAMPLES);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [2:0] clamp_channels(input logic [2:0] v);
        logic [2:0] r;
        if (v == 3'd0) begin
            r = 3'd1;
        end else if (int'(v) > MAX_CHANNELS) begin
            r = 3'(MAX_CHANNELS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    // Register decode; writes beyond the list are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (cfg_index)
                CFG_LINE_SAMPLES:   cfg_next.line_samples   = clamp_lines(cfg_data);
                CFG_LINE_COUNT:     cfg_next.line_count     = clamp_lines(cfg_data);
                CFG_CHANNEL_COUNT:  cfg_next.channel_count  = clamp_channels(cfg_data[2:0]);
                CFG_CHANNEL_SELECT: cfg_next.channel_select = cfg_data[1:0];
                CFG_OUT_LINE_WIDTH: cfg_next.out_line_width = cfg_data;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_samples   <= LS_RESET;
            cfg_reg.line_count     <= LC_RESET;
            cfg_reg.channel_count  <= 3'd1;
            cfg_reg.channel_select <= 2'd0;
            cfg_reg.out_line_width <= 13'd1024;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/rslr_sequencer.sv
module rslr_sequencer #(
    parameter int MAX_LINE_SAMPLES = rslr_pkg::MAX_LINE_SAMPLES_DEF,
    localparam int AW = $clog2(MAX_LINE_SAMPLES)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rslr_pkg::rslr_cfg_t     cfg,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  rslr_pkg::rslr_in_t      s_data,
    output rslr_pkg::rslr_mem_cmd_t mem_cmd,
    output logic [AW-1:0]           mem_addr,
    output logic                    tag_valid,
    output rslr_pkg::rslr_tag_t     tag
);
    import rslr_pkg::*;

    localparam logic [PIXEL_W-1:0] PIXEL_MASK = (SAMPLE_BITS >= PIXEL_W) ?
        {PIXEL_W{1'b1}} : PIXEL_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic [11:0] pos_reg, pos_next;
    logic [1:0]  chan_reg, chan_next;
    logic [11:0] line_reg, line_next;
    logic [12:0] tp_reg, tp_next;

    logic        accept;
    logic        idx_ok;
    logic        pos_ok;
    logic        selected;
    logic        last_sample;
    logic        last_chan;
    logic        last_line;
    logic [12:0] tp_base;
    logic [12:0] idx_plus;

    assign accept = s_valid && s_ready;
    assign idx_ok = int'(s_data.table_index) < MAX_LINE_SAMPLES;
    assign pos_ok = int'(pos_reg) < MAX_LINE_SAMPLES;

    // End-of-count tests for the sample, channel and line counters.
    assign last_sample = (13'(pos_reg) + 13'd1) >= cfg.line_samples;
    assign last_chan   = (3'(chan_reg) + 3'd1) >= cfg.channel_count;
    assign last_line   = (13'(line_reg) + 13'd1) >= cfg.line_count;
    assign selected    = (chan_reg == cfg.channel_select) && pos_ok;

    // A load to index zero starts a new table, so the turnaround point starts over.
    assign tp_base  = (s_data.table_index == '0) ? 13'd0 : tp_reg;
    assign idx_plus = 13'(s_data.table_index) + 13'd1;

    // Counter and turnaround update for an accepted transfer.
    always_comb begin
        pos_next  = pos_reg;
        chan_next = chan_reg;
        line_next = line_reg;
        tp_next   = tp_reg;
        if (accept) begin
            unique case (s_data.cmd)
                CMD_LOAD: begin
                    if (idx_ok) begin
                        if (s_data.table_index == '0) begin
                            pos_next  = '0;
                            chan_next = '0;
                            line_next = '0;
                        end
                        if ((s_data.table_column < cfg.out_line_width) &&
                            (idx_plus > tp_base)) begin
                            tp_next = idx_plus;
                        end else begin
                            tp_next = tp_base;
                        end
                    end
                end
                CMD_SAMPLE: begin
                    if (last_sample) begin
                        pos_next = '0;
                        if (last_chan) begin
                            chan_next = '0;
                            line_next = last_line ? 12'd0 : line_reg + 12'd1;
                        end else begin
                            chan_next = chan_reg + 2'd1;
                        end
                    end else begin
                        pos_next = pos_reg + 12'd1;
                    end
                end
            endcase
        end
    end

    // Table access: loads write at the given index, samples read at the position.
    always_comb begin
        mem_cmd.wr_en   = accept && (s_data.cmd == CMD_LOAD) && idx_ok;
        mem_cmd.rd_en   = accept && (s_data.cmd == CMD_SAMPLE) && selected;
        mem_cmd.wr_data = s_data.table_column;
        mem_addr        = (s_data.cmd == CMD_LOAD) ? AW'(s_data.table_index) : AW'(pos_reg);
    end

    // Description of the write that the read entry will complete.
    always_comb begin
        tag_valid     = mem_cmd.rd_en;
        tag.forward   = 13'(pos_reg) < tp_reg;
        tag.row       = {line_reg, ~tag.forward};
        tag.pixel     = s_data.sample_value & PIXEL_MASK;
        tag.frame_end = last_sample && last_line;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            chan_reg <= '0;
            line_reg <= '0;
            tp_reg   <= '0;
        end else begin
            pos_reg  <= pos_next;
            chan_reg <= chan_next;
            line_reg <= line_next;
            tp_reg   <= tp_next;
        end
    end

endmodule

// File: sv/rslr_column_ram.sv
module rslr_column_ram #(
    parameter int MAX_LINE_SAMPLES = rslr_pkg::MAX_LINE_SAMPLES_DEF,
    localparam int AW = $clog2(MAX_LINE_SAMPLES)
) (
    input  logic                              aclk,
    input  rslr_pkg::rslr_mem_cmd_t           mem_cmd,
    input  logic [AW-1:0]                     mem_addr,
    output logic [rslr_pkg::COLUMN_W-1:0]     rd_data
);
    import rslr_pkg::*;

    logic [COLUMN_W-1:0] mem [MAX_LINE_SAMPLES];
    logic [COLUMN_W-1:0] rd_data_reg;

    // Single port: one write or one registered read per cycle. The read register
    // holds its value until the next read.
    always_ff @(posedge aclk) begin
        if (mem_cmd.wr_en) begin
            mem[mem_addr] <= mem_cmd.wr_data;
        end
        if (mem_cmd.rd_en) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/rslr_emit.sv
module rslr_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [12:0]                   out_line_width,
    input  logic                          tag_valid,
    input  rslr_pkg::rslr_tag_t           tag,
    input  logic [rslr_pkg::COLUMN_W-1:0] rd_data,
    output logic                          s_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rslr_pkg::rslr_out_t           m_data
);
    import rslr_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    rslr_tag_t s1_tag_reg;
    logic      m_valid_reg, m_valid_next;
    rslr_out_t m_data_reg, m_data_next;
    logic      out_free;
    logic      s1_free;

    // The read stage and the output register each stall only when the next one is full.
    assign out_free = !m_valid_reg || m_ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign s_ready  = s1_free;

    always_comb begin
        s1_valid_next = s1_free ? tag_valid : s1_valid_reg;
        m_valid_next  = out_free ? s1_valid_reg : m_valid_reg;
    end

    // Return-line samples are shifted back by one output row width.
    always_comb begin
        m_data_next.dest_row    = s1_tag_reg.row;
        m_data_next.dest_column = s1_tag_reg.forward ? rd_data : rd_data - out_line_width;
        m_data_next.pixel_value = s1_tag_reg.pixel;
        m_data_next.frame_end   = s1_tag_reg.frame_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_free && tag_valid) begin
            s1_tag_reg <= tag;
        end
        if (out_free && s1_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: sv/resonant_scan_line_remapper.sv
// An accepted sample transfer is registered into the table read register and the read stage,
// then into the output register behind m_valid. Throughput: one transfer per cycle while
// s_ready is high, loads and samples alike; the column table has a single port and each
// transfer uses it once, writing for a load and reading for a sample.
// Reset (aresetn low, synchronous) clears the counters, the turnaround point and both stages
// and loads the register defaults; the column table is not cleared and must be loaded.
module resonant_scan_line_remapper #(
    parameter int MAX_LINE_SAMPLES = rslr_pkg::MAX_LINE_SAMPLES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rslr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rslr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  rslr_pkg::rslr_in_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output rslr_pkg::rslr_out_t            m_data
);
    import rslr_pkg::*;

    localparam int AW = $clog2(MAX_LINE_SAMPLES);

    rslr_cfg_t           cfg;
    rslr_mem_cmd_t       mem_cmd;
    logic [AW-1:0]       mem_addr;
    logic [COLUMN_W-1:0] rd_data;
    logic                tag_valid;
    rslr_tag_t           tag;

    rslr_cfg_regs #(
        .MAX_LINE_SAMPLES(MAX_LINE_SAMPLES)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rslr_sequencer #(
        .MAX_LINE_SAMPLES(MAX_LINE_SAMPLES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .mem_cmd   (mem_cmd),
        .mem_addr  (mem_addr),
        .tag_valid (tag_valid),
        .tag       (tag)
    );

    rslr_column_ram #(
        .MAX_LINE_SAMPLES(MAX_LINE_SAMPLES)
    ) u_ram (
        .aclk     (aclk),
        .mem_cmd  (mem_cmd),
        .mem_addr (mem_addr),
        .rd_data  (rd_data)
    );

    rslr_emit u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .out_line_width (cfg.out_line_width),
        .tag_valid      (tag_valid),
        .tag            (tag),
        .rd_data        (rd_data),
        .s_ready        (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

// File: sv/rslr_checker.sv
module rslr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rslr_pkg::rslr_out_t m_data
);
    import rslr_pkg::*;

    logic s_xfer;

    assign s_xfer = s_valid && s_ready;

    // A stalled result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or vanished while stalled");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // With the output register empty, the input side is never stalled.
    a_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // An idle stretch with no result shown and no transfer taken means nothing is left in flight.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && !s_xfer) ##1 (!m_valid && !s_xfer) |=> !m_valid)
        else $error("result appeared without a transfer");

endmodule

bind resonant_scan_line_remapper rslr_checker u_rslr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
